@@ hdl/tlvp_pkg.sv @@
`timescale 1ns / 1ps

package tlvp_pkg;

	localparam logic [7:0] TAG_EXT  = 8'hBF;
	localparam logic [7:0] LEN_ONE  = 8'h81;
	localparam logic [7:0] LEN_TWO  = 8'h82;
	localparam logic [7:0] PAD_BYTE = 8'hFF;
	localparam logic [7:0] SHORT_LIMIT = 8'h80;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_CONTENT = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] record_tag;
		logic [15:0] record_length;
		logic [7:0]  content_byte;
		logic        last_of_record;
	} result_t;

	// Step outcome from the parse core to the top level
	typedef struct packed {
		logic    has_result;
		result_t result;
	} step_t;

endpackage

@@ hdl/tlvp_stream_if.sv @@
`timescale 1ns / 1ps

interface tlvp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface tlvp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] record_tag;
	logic [15:0] record_length;
	logic [7:0]  content_byte;
	logic        last_of_record;

	modport source (output valid, output kind, output record_tag, output record_length,
		output content_byte, output last_of_record, input ready);
	modport sink   (input valid, input kind, input record_tag, input record_length,
		input content_byte, input last_of_record, output ready);
endinterface

@@ hdl/tlv_record_stream_parser.sv @@
`timescale 1ns / 1ps

// Splits a byte stream into tag-length-value records: one- or two-byte tags
// (0xBF lead), short, 0x81 or 0x82 lengths, then the content bytes, with 0xFF
// padding dropped between records. Takes one byte per clock at full rate;
// each request goes through an input register, the parse core updates its
// state from that byte, and any result lands in the output register. Tag,
// length and padding bytes produce no result; the header result comes with
// the last length byte. A result is written to the output register when its
// byte leaves the input register, and the input keeps taking bytes while a
// result waits, stalling only when the output register is full, not being
// drained, and the held byte would produce another result.
module tlv_record_stream_parser (
	input  logic           clk,
	input  logic           arst_n,
	tlvp_byte_if.sink      byte_in,
	tlvp_result_if.source  result_out
);
	import tlvp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       s1_fire;
	step_t      step;

	logic       out_valid_q;
	result_t    out_q;

	// Advance the held byte unless its result would overwrite a pending one
	assign s1_fire = valid_s1 && (!step.has_result || !out_valid_q || result_out.ready);
	assign byte_in.ready = !valid_s1 || s1_fire;

	tlvp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (byte_s1),
		.fire      (s1_fire),
		.step      (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && step.has_result) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && step.has_result) begin
			out_q <= step.result;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.kind           = out_q.kind;
	assign result_out.record_tag     = out_q.record_tag;
	assign result_out.record_length  = out_q.record_length;
	assign result_out.content_byte   = out_q.content_byte;
	assign result_out.last_of_record = out_q.last_of_record;

endmodule

@@ hdl/tlvp_parse_core.sv @@
`timescale 1ns / 1ps

module tlvp_parse_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    data_byte,
	input  logic          fire,
	output tlvp_pkg::step_t step
);
	import tlvp_pkg::*;

	localparam logic [2:0] PH_TAG1  = 3'd0;
	localparam logic [2:0] PH_TAG2  = 3'd1;
	localparam logic [2:0] PH_LEAD  = 3'd2;
	localparam logic [2:0] PH_LEN1B = 3'd3;
	localparam logic [2:0] PH_LENHI = 3'd4;
	localparam logic [2:0] PH_LENLO = 3'd5;
	localparam logic [2:0] PH_DATA  = 3'd6;

	logic [2:0]  phase_q, phase_d;
	logic [15:0] tag_q, tag_d;
	logic [15:0] length_q, length_d;
	logic [15:0] remaining_q, remaining_d;
	logic        after_q, after_d;
	logic        header_now;

	always_comb begin
		phase_d     = phase_q;
		tag_d       = tag_q;
		length_d    = length_q;
		remaining_d = remaining_q;
		after_d     = after_q;
		header_now  = 1'b0;
		step        = '0;

		unique case (phase_q)
			PH_TAG2: begin
				tag_d   = {TAG_EXT, data_byte};
				phase_d = PH_LEAD;
			end
			PH_LEAD: begin
				if (data_byte == LEN_ONE) begin
					phase_d = PH_LEN1B;
				end else if (data_byte == LEN_TWO) begin
					phase_d = PH_LENHI;
				end else if (data_byte < SHORT_LIMIT) begin
					length_d   = {8'h00, data_byte};
					header_now = 1'b1;
				end else begin
					length_d = '0;
					phase_d  = PH_TAG1;
					after_d  = 1'b0;
					step.has_result            = 1'b1;
					step.result.kind           = KIND_ERROR;
					step.result.last_of_record = 1'b1;
				end
			end
			PH_LEN1B: begin
				length_d   = {8'h00, data_byte};
				header_now = 1'b1;
			end
			PH_LENHI: begin
				length_d = {data_byte, 8'h00};
				phase_d  = PH_LENLO;
			end
			PH_LENLO: begin
				length_d   = {length_q[15:8], data_byte};
				header_now = 1'b1;
			end
			PH_DATA: begin
				step.has_result          = 1'b1;
				step.result.kind         = KIND_CONTENT;
				step.result.content_byte = data_byte;
				if (remaining_q <= 16'd1) begin
					step.result.last_of_record = 1'b1;
					remaining_d = '0;
					phase_d     = PH_TAG1;
					after_d     = 1'b1;
				end else begin
					remaining_d = remaining_q - 16'd1;
				end
			end
			default: begin
				// Drop padding only right after a finished record
				if (!(after_q && data_byte == PAD_BYTE)) begin
					after_d = 1'b0;
					if (data_byte == TAG_EXT) begin
						tag_d   = {TAG_EXT, 8'h00};
						phase_d = PH_TAG2;
					end else begin
						tag_d   = {8'h00, data_byte};
						phase_d = PH_LEAD;
					end
				end
			end
		endcase

		if (header_now) begin
			step.has_result  = 1'b1;
			step.result.kind = KIND_HEADER;
			if (length_d == 16'd0) begin
				step.result.last_of_record = 1'b1;
				phase_d = PH_TAG1;
				after_d = 1'b1;
			end else begin
				remaining_d = length_d;
				phase_d     = PH_DATA;
			end
		end

		step.result.record_tag    = tag_d;
		step.result.record_length = length_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TAG1;
			tag_q       <= '0;
			length_q    <= '0;
			remaining_q <= '0;
			after_q     <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_d;
			tag_q       <= tag_d;
			length_q    <= length_d;
			remaining_q <= remaining_d;
			after_q     <= after_d;
		end
	end

	a_error_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && step.has_result && step.result.kind == KIND_ERROR)
		|=> (phase_q == PH_TAG1 && !after_q))
		else $error("error result did not return to tag phase");

	a_empty_header: assert property (@(posedge clk) disable iff (!arst_n)
		(step.has_result && step.result.kind == KIND_HEADER)
		|-> (step.result.last_of_record == (step.result.record_length == 16'd0)))
		else $error("header last flag disagrees with length");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (remaining_q != 16'd0))
		else $error("content phase with nothing remaining");

	a_last_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && step.has_result && step.result.last_of_record)
		|=> (phase_q == PH_TAG1))
		else $error("record end did not return to tag phase");

endmodule

@@ tb/sv/tlv_record_stream_parser_test.sv @@
`timescale 1ns / 1ps

module tlv_record_stream_parser_test;
	import tlvp_pkg::*;

	class record_scoreboard;
		typedef enum logic [2:0] {
			WAIT_TAG,
			WAIT_TAG_LOW,
			WAIT_LEAD,
			WAIT_LEN_BYTE,
			WAIT_LEN_HIGH,
			WAIT_LEN_LOW,
			WAIT_CONTENT
		} parse_phase_e;

		parse_phase_e phase;
		logic [15:0]  tag;
		logic [15:0]  length;
		logic [15:0]  remaining;
		bit           pad_skip;
		result_t      pending[$];
		int           mismatches;

		function new();
			phase      = WAIT_TAG;
			tag        = '0;
			length     = '0;
			remaining  = '0;
			pad_skip   = 1'b0;
			mismatches = 0;
		endfunction

		function result_t make_result(logic [1:0] kind, logic [7:0] content, logic last);
			result_t r;
			r.kind           = kind;
			r.record_tag     = tag;
			r.record_length  = length;
			r.content_byte   = content;
			r.last_of_record = last;
			return r;
		endfunction

		// Length is complete: header goes out, zero length closes the record at once
		function result_t close_header();
			logic last;
			last = (length == 16'd0);
			if (last) begin
				phase    = WAIT_TAG;
				pad_skip = 1'b1;
			end else begin
				remaining = length;
				phase     = WAIT_CONTENT;
			end
			return make_result(KIND_HEADER, 8'd0, last);
		endfunction

		function void note_byte(logic [7:0] b);
			result_t r;
			bit      has;
			logic    last;
			has = 1'b0;
			case (phase)
				WAIT_TAG_LOW: begin
					tag   = {TAG_EXT, b};
					phase = WAIT_LEAD;
				end
				WAIT_LEAD: begin
					if (b == LEN_ONE) begin
						phase = WAIT_LEN_BYTE;
					end else if (b == LEN_TWO) begin
						phase = WAIT_LEN_HIGH;
					end else if (b < SHORT_LIMIT) begin
						length = {8'd0, b};
						r      = close_header();
						has    = 1'b1;
					end else begin
						length   = '0;
						r        = make_result(KIND_ERROR, 8'd0, 1'b1);
						has      = 1'b1;
						phase    = WAIT_TAG;
						pad_skip = 1'b0;
					end
				end
				WAIT_LEN_BYTE: begin
					length = {8'd0, b};
					r      = close_header();
					has    = 1'b1;
				end
				WAIT_LEN_HIGH: begin
					length = {b, 8'd0};
					phase  = WAIT_LEN_LOW;
				end
				WAIT_LEN_LOW: begin
					length = {length[15:8], b};
					r      = close_header();
					has    = 1'b1;
				end
				WAIT_CONTENT: begin
					last      = (remaining <= 16'd1);
					r         = make_result(KIND_CONTENT, b, last);
					has       = 1'b1;
					remaining = remaining - 16'd1;
					if (last) begin
						remaining = '0;
						phase     = WAIT_TAG;
						pad_skip  = 1'b1;
					end
				end
				default: begin
					// padding only counts right after a completed record
					if (!(pad_skip && b == PAD_BYTE)) begin
						pad_skip = 1'b0;
						if (b == TAG_EXT) begin
							tag   = {TAG_EXT, 8'd0};
							phase = WAIT_TAG_LOW;
						end else begin
							tag   = {8'd0, b};
							phase = WAIT_LEAD;
						end
					end
				end
			endcase
			if (has)
				pending = {pending, r};
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("result with nothing expected: kind 0x%0h tag 0x%0h", got.kind,
					got.record_tag);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("record_tag", want.record_tag, got.record_tag);
			compare_field("record_length", want.record_length, got.record_length);
			compare_field("content_byte", want.content_byte, got.content_byte);
			compare_field("last_of_record", want.last_of_record, got.last_of_record);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	tlvp_byte_if   byte_if ();
	tlvp_result_if result_if ();

	tlv_record_stream_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_if),
		.result_out (result_if)
	);

	record_scoreboard sb = new();
	logic [7:0]       byte_plan[$];
	bit               plan_after_record = 1'b0;
	bit               steady = 1'b0;

	always #5 clk = ~clk;

	function automatic void queue_byte(logic [7:0] b);
		byte_plan = {byte_plan, b};
	endfunction

	function automatic void plan_tag();
		logic [7:0] lo;
		if ($urandom_range(3) == 0) begin
			queue_byte(TAG_EXT);
			queue_byte(8'($urandom_range(255)));
		end else begin
			lo = 8'($urandom_range(255));
			// keep the record aligned: avoid an extension lead or a byte that padding eats
			if (lo == TAG_EXT || (lo == PAD_BYTE && plan_after_record))
				lo = 8'hFE;
			queue_byte(lo);
		end
	endfunction

	function automatic void plan_record();
		int len;
		int form;
		int pick;
		plan_tag();
		pick = $urandom_range(99);
		if (pick < 80)
			len = $urandom_range(12);
		else if (pick < 95)
			len = $urandom_range(300, 13);
		else
			case ($urandom_range(2))
				0: len = 127;
				1: len = 255;
				default: len = 256;
			endcase
		if (len < 128)
			form = $urandom_range(2);
		else if (len < 256)
			form = $urandom_range(2, 1);
		else
			form = 2;
		case (form)
			0: queue_byte(8'(len));
			1: begin
				queue_byte(LEN_ONE);
				queue_byte(8'(len));
			end
			default: begin
				queue_byte(LEN_TWO);
				queue_byte(8'(len >> 8));
				queue_byte(8'(len));
			end
		endcase
		repeat (len) queue_byte(8'($urandom_range(255)));
		plan_after_record = 1'b1;
		if ($urandom_range(99) < 30)
			repeat ($urandom_range(3, 1)) queue_byte(PAD_BYTE);
	endfunction

	function automatic void plan_broken();
		plan_tag();
		if ($urandom_range(1) == 0)
			queue_byte(SHORT_LIMIT);
		else
			queue_byte(8'($urandom_range(255, 8'h83)));
		plan_after_record = 1'b0;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		if (!steady && $urandom_range(99) < 33) begin
			byte_if.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		byte_if.valid     <= 1'b1;
		byte_if.data_byte <= b;
		do
			@(posedge clk);
		while (!byte_if.ready);
		sb.note_byte(b);
	endtask

	// result side: check on accept, then pick ready for the next cycle
	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_if.valid && result_if.ready)
				sb.check_result('{result_if.kind, result_if.record_tag,
					result_if.record_length, result_if.content_byte,
					result_if.last_of_record});
			result_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 33);
		end
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int idx;
		arst_n            <= 1'b0;
		byte_if.valid     <= 1'b0;
		byte_if.data_byte <= 8'd0;

		// padding byte as the first tag of the stream, zero short length
		byte_plan = '{8'hFF, 8'h00,
			// padding, two-byte tag, one-byte length form, two content bytes
			8'hFF, 8'hFF, TAG_EXT, 8'h00, LEN_ONE, 8'h02, 8'hC3, 8'h3C,
			// padding then invalid lead 0x80
			8'hFF, 8'h01, SHORT_LIMIT,
			// after an error 0xFF is a tag again; lowest invalid lead above 0x82
			8'hFF, 8'h83,
			// two-byte tag with 0xFF low byte, lead 0xFF is invalid
			TAG_EXT, 8'hFF, 8'hFF,
			// two-byte length form, one content byte
			8'h7F, LEN_TWO, 8'h00, 8'h01, 8'h55,
			// zero length in two-byte form
			TAG_EXT, 8'h80, LEN_TWO, 8'h00, 8'h00};
		plan_after_record = 1'b1;
		while (byte_plan.size() < 1030) begin
			if ($urandom_range(99) < 85)
				plan_record();
			else
				plan_broken();
		end
		// widest length last; the stream ends inside its content
		plan_tag();
		queue_byte(LEN_TWO);
		queue_byte(8'hFF);
		queue_byte(8'hFF);
		repeat (16) queue_byte(8'($urandom_range(255)));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (idx = 0; idx < byte_plan.size(); idx++) begin
			steady = (idx >= 350 && idx < 650);
			send_byte(byte_plan[idx]);
		end
		byte_if.valid <= 1'b0;
		steady = 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
